// File: rtl/core/dti_pkg.sv
// ----------------------------------------------------------------------------
// dti_pkg
// shared types, constants, the micro-op builder and the micro-program rom
// ----------------------------------------------------------------------------
package dti_pkg;

  localparam int STEP_LIMIT = 65536;
  localparam int CNT_MAX    = 131071;
  localparam logic [16:0] STEP_CAP = 17'((STEP_LIMIT > CNT_MAX) ? CNT_MAX : STEP_LIMIT);

  localparam int MUL_W = 34;
  localparam int PRD_W = 2 * MUL_W;
  localparam int PC_W  = 6;

  localparam logic [PC_W-1:0] ADV_PC    = PC_W'(0);
  localparam logic [PC_W-1:0] LAUNCH_PC = PC_W'(40);

  typedef logic signed [71:0] wide_t;

  typedef enum logic {
    OP_LAUNCH  = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_STEP_TIME     = 3'd0,
    REG_DRAG_COEFF    = 3'd1,
    REG_ALONG_DIR_Z   = 3'd2,
    REG_ACROSS_DIR_Z  = 3'd3,
    REG_STOP_HEIGHT   = 3'd4,
    REG_TARGET_ALONG  = 3'd5,
    REG_TARGET_ACROSS = 3'd6
  } reg_idx_t;

  // multiplier operand pairs
  typedef enum logic [4:0] {
    MS_NONE, MS_GA, MS_GC, MS_DTDT, MS_VXVX, MS_VYVY, MS_KSPD, MS_DVX, MS_DVY,
    MS_VADT, MS_AXDT2, MS_VCDT, MS_AYDT2, MS_AXDT, MS_AYDT, MS_SUMXDT, MS_SUMYDT,
    MS_DADA, MS_DCDC, MS_UAPA, MS_UCPC, MS_UAVA, MS_UCVC
  } mul_sel_t;

  // write-back targets, mostly consumers of the registered product
  typedef enum logic [4:0] {
    WB_NONE, WB_LDV, WB_GA, WB_GC, WB_DT2, WB_SQ, WB_SQADD, WB_DRAG, WB_AX, WB_AY,
    WB_BX, WB_BY, WB_ACC2, WB_PX, WB_PY, WB_VPX, WB_VPY, WB_VELA, WB_VELC, WB_D2A,
    WB_D2, WB_BEST, WB_PZ, WB_VZ, WB_STOP, WB_LAUNCH, WB_LBEST
  } wb_sel_t;

  typedef struct packed {
    mul_sel_t mul;
    wb_sel_t  wb;
    logic     sqrt;
    logic     last;
  } uop_t;

  typedef struct packed {
    logic     take;
    mul_sel_t mul;
    wb_sel_t  wb;
    logic     sqrt_start;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic done;
    logic out_free;
  } dp_status_t;

  function automatic uop_t mk(mul_sel_t m, wb_sel_t w, logic s, logic l);
    uop_t u;
    u.mul  = m;
    u.wb   = w;
    u.sqrt = s;
    u.last = l;
    return u;
  endfunction

  function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
    uop_t u;
    u = mk(MS_NONE, WB_NONE, 1'b0, 1'b1);
    case (pc)
      6'd0:  u = mk(MS_GA,     WB_LDV,   1'b0, 1'b0);
      6'd1:  u = mk(MS_GC,     WB_GA,    1'b0, 1'b0);
      6'd2:  u = mk(MS_DTDT,   WB_GC,    1'b0, 1'b0);
      6'd3:  u = mk(MS_VXVX,   WB_DT2,   1'b0, 1'b0);
      6'd4:  u = mk(MS_VYVY,   WB_SQ,    1'b0, 1'b0);
      6'd5:  u = mk(MS_NONE,   WB_SQADD, 1'b0, 1'b0);
      6'd6:  u = mk(MS_NONE,   WB_NONE,  1'b1, 1'b0);
      6'd7:  u = mk(MS_KSPD,   WB_NONE,  1'b0, 1'b0);
      6'd8:  u = mk(MS_NONE,   WB_DRAG,  1'b0, 1'b0);
      6'd9:  u = mk(MS_DVX,    WB_NONE,  1'b0, 1'b0);
      6'd10: u = mk(MS_DVY,    WB_AX,    1'b0, 1'b0);
      6'd11: u = mk(MS_NONE,   WB_AY,    1'b0, 1'b0);
      6'd12: u = mk(MS_VADT,   WB_NONE,  1'b0, 1'b0);
      6'd13: u = mk(MS_AXDT2,  WB_ACC2,  1'b0, 1'b0);
      6'd14: u = mk(MS_VCDT,   WB_PX,    1'b0, 1'b0);
      6'd15: u = mk(MS_AYDT2,  WB_ACC2,  1'b0, 1'b0);
      6'd16: u = mk(MS_AXDT,   WB_PY,    1'b0, 1'b0);
      6'd17: u = mk(MS_AYDT,   WB_VPX,   1'b0, 1'b0);
      6'd18: u = mk(MS_VXVX,   WB_VPY,   1'b0, 1'b0);
      6'd19: u = mk(MS_VYVY,   WB_SQ,    1'b0, 1'b0);
      6'd20: u = mk(MS_NONE,   WB_SQADD, 1'b0, 1'b0);
      6'd21: u = mk(MS_NONE,   WB_NONE,  1'b1, 1'b0);
      6'd22: u = mk(MS_KSPD,   WB_NONE,  1'b0, 1'b0);
      6'd23: u = mk(MS_NONE,   WB_DRAG,  1'b0, 1'b0);
      6'd24: u = mk(MS_DVX,    WB_NONE,  1'b0, 1'b0);
      6'd25: u = mk(MS_DVY,    WB_BX,    1'b0, 1'b0);
      6'd26: u = mk(MS_SUMXDT, WB_BY,    1'b0, 1'b0);
      6'd27: u = mk(MS_SUMYDT, WB_VELA,  1'b0, 1'b0);
      6'd28: u = mk(MS_NONE,   WB_VELC,  1'b0, 1'b0);
      6'd29: u = mk(MS_DADA,   WB_NONE,  1'b0, 1'b0);
      6'd30: u = mk(MS_DCDC,   WB_D2A,   1'b0, 1'b0);
      6'd31: u = mk(MS_UAPA,   WB_D2,    1'b0, 1'b0);
      6'd32: u = mk(MS_UCPC,   WB_BEST,  1'b0, 1'b0);
      6'd33: u = mk(MS_UAVA,   WB_PZ,    1'b0, 1'b0);
      6'd34: u = mk(MS_UCVC,   WB_VZ,    1'b0, 1'b0);
      6'd35: u = mk(MS_NONE,   WB_STOP,  1'b0, 1'b1);
      6'd40: u = mk(MS_NONE,   WB_LAUNCH, 1'b0, 1'b0);
      6'd41: u = mk(MS_DADA,   WB_NONE,  1'b0, 1'b0);
      6'd42: u = mk(MS_DCDC,   WB_D2A,   1'b0, 1'b0);
      6'd43: u = mk(MS_NONE,   WB_LBEST, 1'b0, 1'b1);
      default: u = mk(MS_NONE, WB_NONE,  1'b0, 1'b1);
    endcase
    return u;
  endfunction

endpackage

// File: rtl/core/dti_if.sv
// ----------------------------------------------------------------------------
// dti_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface dti_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [22:0] launch_speed;

  modport source(output valid, output operation, output launch_speed, input ready);
  modport sink(input valid, input operation, input launch_speed, output ready);
endinterface

interface dti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_along;
  logic signed [31:0] pos_across;
  logic signed [31:0] vel_along;
  logic signed [31:0] vel_across;
  logic [16:0]        step_index;
  logic               stopped;
  logic [16:0]        nearest_index;
  logic [62:0]        nearest_dist2;

  modport source(output valid, output pos_along, output pos_across, output vel_along,
                 output vel_across, output step_index, output stopped,
                 output nearest_index, output nearest_dist2, input ready);
  modport sink(input valid, input pos_along, input pos_across, input vel_along,
               input vel_across, input step_index, input stopped,
               input nearest_index, input nearest_dist2, output ready);
endinterface

// File: rtl/core/dti_sqrt.sv
// ----------------------------------------------------------------------------
// dti_sqrt
// floor square root of a 64-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module dti_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= radicand;
      res_r <= '0;
      bit_r <= 64'(1) << 62;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

// File: rtl/core/dti_ctrl.sv
// ----------------------------------------------------------------------------
// dti_ctrl
// sequencer: walks the micro-program and hands commands to the datapath
// ----------------------------------------------------------------------------
module dti_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  dti_in_if.sink              in_ch,
  input  dti_pkg::dp_status_t status,
  output dti_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_SQRT, S_DONE} state_t;

  state_t                      state_r;
  logic [dti_pkg::PC_W-1:0]    pc_r;
  dti_pkg::uop_t               uop;
  logic                        take;

  assign uop         = dti_pkg::uop_rom(pc_r);
  assign in_ch.ready = (state_r == S_IDLE);
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    cmd.take       = take;
    cmd.mul        = (state_r == S_RUN) ? uop.mul : dti_pkg::MS_NONE;
    cmd.wb         = (state_r == S_RUN) ? uop.wb  : dti_pkg::WB_NONE;
    cmd.sqrt_start = (state_r == S_RUN) && uop.sqrt;
    cmd.load_out   = (state_r == S_DONE) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= dti_pkg::ADV_PC;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            if (dti_pkg::op_t'(in_ch.operation) == dti_pkg::OP_LAUNCH) begin
              pc_r    <= dti_pkg::LAUNCH_PC;
              state_r <= S_RUN;
            end else if (status.done) begin
              state_r <= S_DONE;
            end else begin
              pc_r    <= dti_pkg::ADV_PC;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (uop.sqrt) begin
            state_r <= S_SQRT;
          end else if (uop.last) begin
            state_r <= S_DONE;
          end else begin
            pc_r <= pc_r + 1'b1;
          end
        end
        S_SQRT: begin
          if (status.sqrt_done) begin
            pc_r    <= pc_r + 1'b1;
            state_r <= S_RUN;
          end
        end
        S_DONE: begin
          if (status.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !in_ch.ready)
    else $error("input taken while an item is in flight");
  a_sqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_start |=> (state_r == S_SQRT))
    else $error("sqrt issued without waiting");
  a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    status.sqrt_done |-> (state_r == S_SQRT))
    else $error("sqrt finished outside its wait state");
`endif

endmodule

// File: rtl/core/dti_dp.sv
// ----------------------------------------------------------------------------
// dti_dp
// datapath: config registers, trajectory state, shared multiplier, sqrt unit
// ----------------------------------------------------------------------------
module dti_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  input  logic [22:0]         launch_speed,
  input  dti_pkg::dp_cmd_t    cmd,
  output dti_pkg::dp_status_t status,
  dti_out_if.source           out_ch
);

  localparam logic signed [dti_pkg::MUL_W-1:0] NEG_GRAV = -34'sd642908;
  localparam logic signed [31:0] DIR_ONE = 32'sd1073741824;

  // config
  logic [23:0]        dt_r, k_r;
  logic signed [31:0] ua_r, uc_r, stop_h_r, ta_r, tc_r;
  // trajectory state
  logic signed [31:0] pos_a_r, pos_c_r, vel_a_r, vel_c_r;
  logic [16:0]        step_r, best_idx_r;
  logic               done_r;
  logic [62:0]        best_d2_r;
  logic               out_valid_r;
  // scratch
  logic [22:0]        speed_in_r;
  logic signed [31:0] vx_r, vy_r, ax_r, ay_r, bx_r, by_r, px_r, py_r, ga_r, gc_r;
  logic [24:0]        dt2_r;
  logic [63:0]        sq_r;
  logic [31:0]        drag_r;
  dti_pkg::wide_t     acc_r;
  logic [62:0]        d2_r;
  logic signed [63:0] pz_r, vz_r;
  logic signed [dti_pkg::PRD_W-1:0] prod_r;

  logic signed [dti_pkg::MUL_W-1:0] ma, mb;
  dti_pkg::wide_t     p_w;
  logic [31:0]        root;
  logic               sqrt_done;
  logic [62:0]        p_sat, d2_sum;
  logic signed [63:0] vz_sum, thr;
  logic [39:0]        drag_full;

  function automatic dti_pkg::wide_t rnd_shr(dti_pkg::wide_t v, int unsigned sh);
    logic [71:0] m;
    m = v[71] ? 72'(-v) : 72'(v);
    m = (m + (72'(1) << (sh - 1))) >> sh;
    return v[71] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(dti_pkg::wide_t v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [62:0] sat63(logic [64:0] v);
    return (v > 65'h7fffffffffffffff) ? '1 : v[62:0];
  endfunction

  function automatic logic signed [31:0] clamp_dir(logic signed [31:0] s);
    if (s > DIR_ONE) return DIR_ONE;
    if (s < -DIR_ONE) return -DIR_ONE;
    return s;
  endfunction

  dti_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sq_r),
    .done     (sqrt_done),
    .root     (root)
  );

  // operand selection for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul)
      dti_pkg::MS_GA:     begin ma = NEG_GRAV;        mb = 34'(ua_r);    end
      dti_pkg::MS_GC:     begin ma = NEG_GRAV;        mb = 34'(uc_r);    end
      dti_pkg::MS_DTDT:   begin ma = 34'(dt_r);       mb = 34'(dt_r);    end
      dti_pkg::MS_VXVX:   begin ma = 34'(vx_r);       mb = 34'(vx_r);    end
      dti_pkg::MS_VYVY:   begin ma = 34'(vy_r);       mb = 34'(vy_r);    end
      dti_pkg::MS_KSPD:   begin ma = 34'(k_r);        mb = 34'(root);    end
      dti_pkg::MS_DVX:    begin ma = 34'(drag_r);     mb = 34'(vx_r);    end
      dti_pkg::MS_DVY:    begin ma = 34'(drag_r);     mb = 34'(vy_r);    end
      dti_pkg::MS_VADT:   begin ma = 34'(vel_a_r);    mb = 34'(dt_r);    end
      dti_pkg::MS_AXDT2:  begin ma = 34'(ax_r);       mb = 34'(dt2_r);   end
      dti_pkg::MS_VCDT:   begin ma = 34'(vel_c_r);    mb = 34'(dt_r);    end
      dti_pkg::MS_AYDT2:  begin ma = 34'(ay_r);       mb = 34'(dt2_r);   end
      dti_pkg::MS_AXDT:   begin ma = 34'(ax_r);       mb = 34'(dt_r);    end
      dti_pkg::MS_AYDT:   begin ma = 34'(ay_r);       mb = 34'(dt_r);    end
      dti_pkg::MS_SUMXDT: begin ma = 34'(ax_r) + 34'(bx_r); mb = 34'(dt_r); end
      dti_pkg::MS_SUMYDT: begin ma = 34'(ay_r) + 34'(by_r); mb = 34'(dt_r); end
      dti_pkg::MS_DADA: begin
        ma = 34'(pos_a_r) - 34'(ta_r);
        mb = 34'(pos_a_r) - 34'(ta_r);
      end
      dti_pkg::MS_DCDC: begin
        ma = 34'(pos_c_r) - 34'(tc_r);
        mb = 34'(pos_c_r) - 34'(tc_r);
      end
      dti_pkg::MS_UAPA:   begin ma = 34'(ua_r);       mb = 34'(pos_a_r); end
      dti_pkg::MS_UCPC:   begin ma = 34'(uc_r);       mb = 34'(pos_c_r); end
      dti_pkg::MS_UAVA:   begin ma = 34'(ua_r);       mb = 34'(vel_a_r); end
      dti_pkg::MS_UCVC:   begin ma = 34'(uc_r);       mb = 34'(vel_c_r); end
      default:            begin ma = '0;              mb = '0;           end
    endcase
  end

  assign p_w       = dti_pkg::wide_t'(prod_r);
  assign p_sat     = sat63(prod_r[64:0]);
  assign d2_sum    = sat63(65'(sq_r) + 65'(p_sat));
  assign vz_sum    = vz_r + prod_r[63:0];
  assign thr       = {{2{stop_h_r[31]}}, stop_h_r, 30'b0};
  assign drag_full = 40'(rnd_shr(p_w, 16));

  // scratch registers
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (cmd.take) speed_in_r <= launch_speed;
    case (cmd.wb)
      dti_pkg::WB_LDV:   begin vx_r <= vel_a_r; vy_r <= vel_c_r; end
      dti_pkg::WB_GA:    ga_r  <= sat32(rnd_shr(p_w, 30));
      dti_pkg::WB_GC:    gc_r  <= sat32(rnd_shr(p_w, 30));
      dti_pkg::WB_DT2:   dt2_r <= 25'(rnd_shr(p_w, 24));
      dti_pkg::WB_SQ:    sq_r  <= prod_r[63:0];
      dti_pkg::WB_SQADD: sq_r  <= sq_r + prod_r[63:0];
      dti_pkg::WB_DRAG:  drag_r <= (drag_full[39:32] != '0) ? '1 : drag_full[31:0];
      dti_pkg::WB_AX:    ax_r <= sat32(72'(ga_r) - rnd_shr(p_w, 24));
      dti_pkg::WB_AY:    ay_r <= sat32(72'(gc_r) - rnd_shr(p_w, 24));
      dti_pkg::WB_BX:    bx_r <= sat32(72'(ga_r) - rnd_shr(p_w, 24));
      dti_pkg::WB_BY:    by_r <= sat32(72'(gc_r) - rnd_shr(p_w, 24));
      dti_pkg::WB_ACC2:  acc_r <= p_w <<< 1;
      dti_pkg::WB_PX:    px_r <= sat32(72'(pos_a_r) + rnd_shr(acc_r + p_w, 25));
      dti_pkg::WB_PY:    py_r <= sat32(72'(pos_c_r) + rnd_shr(acc_r + p_w, 25));
      dti_pkg::WB_VPX:   vx_r <= sat32(72'(vel_a_r) + rnd_shr(p_w, 24));
      dti_pkg::WB_VPY:   vy_r <= sat32(72'(vel_c_r) + rnd_shr(p_w, 24));
      dti_pkg::WB_D2A:   sq_r <= {1'b0, p_sat};
      dti_pkg::WB_D2:    d2_r <= d2_sum;
      dti_pkg::WB_BEST:  pz_r <= prod_r[63:0];
      dti_pkg::WB_PZ:    pz_r <= pz_r + prod_r[63:0];
      dti_pkg::WB_VZ:    vz_r <= prod_r[63:0];
      default: ;
    endcase
  end

  // config and trajectory state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r        <= 24'd16777;
      k_r         <= 24'd342000;
      ua_r        <= '0;
      uc_r        <= -DIR_ONE;
      stop_h_r    <= -32'sd655360;
      ta_r        <= '0;
      tc_r        <= '0;
      pos_a_r     <= '0;
      pos_c_r     <= '0;
      vel_a_r     <= '0;
      vel_c_r     <= '0;
      step_r      <= '0;
      done_r      <= 1'b1;
      best_idx_r  <= '0;
      best_d2_r   <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (dti_pkg::reg_idx_t'(cfg_idx))
          dti_pkg::REG_STEP_TIME:     dt_r     <= cfg_data[23:0];
          dti_pkg::REG_DRAG_COEFF:    k_r      <= cfg_data[23:0];
          dti_pkg::REG_ALONG_DIR_Z:   ua_r     <= clamp_dir(cfg_data);
          dti_pkg::REG_ACROSS_DIR_Z:  uc_r     <= clamp_dir(cfg_data);
          dti_pkg::REG_STOP_HEIGHT:   stop_h_r <= cfg_data;
          dti_pkg::REG_TARGET_ALONG:  ta_r     <= cfg_data;
          dti_pkg::REG_TARGET_ACROSS: tc_r     <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.wb)
        dti_pkg::WB_LAUNCH: begin
          pos_a_r    <= '0;
          pos_c_r    <= '0;
          vel_a_r    <= 32'(speed_in_r);
          vel_c_r    <= '0;
          step_r     <= '0;
          done_r     <= 1'b0;
          best_idx_r <= '0;
        end
        dti_pkg::WB_VELA: vel_a_r <= sat32(72'(vel_a_r) + rnd_shr(p_w, 25));
        dti_pkg::WB_VELC: begin
          vel_c_r <= sat32(72'(vel_c_r) + rnd_shr(p_w, 25));
          pos_a_r <= px_r;
          pos_c_r <= py_r;
          if (step_r != '1) step_r <= step_r + 17'd1;
        end
        dti_pkg::WB_BEST: begin
          if (d2_r < best_d2_r) begin
            best_d2_r  <= d2_r;
            best_idx_r <= step_r;
          end
        end
        dti_pkg::WB_STOP: begin
          if (((pz_r < thr) && vz_sum[63]) || (step_r >= dti_pkg::STEP_CAP)) done_r <= 1'b1;
        end
        dti_pkg::WB_LBEST: best_d2_r <= d2_sum;
        default: ;
      endcase
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ch.pos_along     <= pos_a_r;
      out_ch.pos_across    <= pos_c_r;
      out_ch.vel_along     <= vel_a_r;
      out_ch.vel_across    <= vel_c_r;
      out_ch.step_index    <= step_r;
      out_ch.stopped       <= done_r;
      out_ch.nearest_index <= best_idx_r;
      out_ch.nearest_dist2 <= best_d2_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign status.sqrt_done = sqrt_done;
  assign status.done      = done_r;
  assign status.out_free  = !out_valid_r || out_ch.ready;

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result load lost");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ch.ready))
    else $error("pending result overwritten");
  a_step_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb == dti_pkg::WB_STOP) |=> (done_r || (step_r < dti_pkg::STEP_CAP)))
    else $error("step limit passed without stopping");
`endif

endmodule

// File: rtl/core/drag_trajectory_integrator_top.sv
// ----------------------------------------------------------------------------
// drag_trajectory_integrator_top
// heun-step projectile integrator with gravity and quadratic drag
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid / ready    | operation, launch_speed
//  out_ch   | out | valid / ready    | pos, vel, step_index, stopped, nearest
//  cfg_*    | in  | cfg_we, no ready | cfg_idx, cfg_data
//
//  one beat in, one beat out; a new item is taken only when the block is idle
//  launch: runs the launch micro-program; advance while stopped: skips the micro-program
//  advance: two square root waits on the shared
//  sqrt unit plus 36 micro-ops through one shared 34x34 multiplier
//  a stalled out_ch holds the sequencer in its done state until the result register frees up
//  reset (rst_n low, synchronous) loads register defaults, no shot launched
// ----------------------------------------------------------------------------
module drag_trajectory_integrator_top (
  input  logic        clk,
  input  logic        rst_n,
  dti_in_if.sink      in_ch,
  dti_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  // command and status between sequencer and datapath
  dti_pkg::dp_cmd_t    cmd;
  dti_pkg::dp_status_t status;

  // sequencer owns the input handshake
  dti_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .status (status),
    .cmd    (cmd)
  );

  // datapath owns config, state and the result register
  dti_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .launch_speed (in_ch.launch_speed),
    .cmd          (cmd),
    .status       (status),
    .out_ch       (out_ch)
  );

endmodule
